// ===== hw/rtl/unipolar_sine_lfo_macros.svh =====
// Assertion macros for the unipolar sine LFO.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef UNIPOLAR_SINE_LFO_MACROS_SVH
`define UNIPOLAR_SINE_LFO_MACROS_SVH

// Concurrent assertion on an explicit clock and synchronous reset.
`define USL_ASSERT_CLKRST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block clock and reset.
`define USL_ASSERT(label, prop, msg) \
   `USL_ASSERT_CLKRST(label, clock, reset, prop, msg)

`endif

// ===== hw/rtl/usl_pkg.sv =====
// Package for the unipolar sine LFO: widths, defaults, CSR indexes, sine ROM builder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package usl_pkg;

   localparam int RATE_W         = 24;
   localparam int SCALE_W        = 20;
   localparam int CSR_DATA_W     = 20;
   localparam int CSR_IDX_W      = 1;
   localparam int PROD_W         = RATE_W + SCALE_W;
   localparam int PHASE_BITS_DEF = 32;
   localparam int TABLE_BITS_DEF = 10;
   localparam int LEVEL_BITS_DEF = 16;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(89478);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED     = 1'b0,
      CSR_PHASE_SCALE = 1'b1
   } usl_csr_idx_type;

   // Level for one ROM entry: (sin(2*pi*i/2^tb) + 1) / 2, quarter-wave symmetry,
   // Q30 Taylor series to x^9, rounded to lb bits. Evaluated at elaboration only.
   function automatic logic [63:0] usl_rom_level(input logic [63:0] idx,
                                                 input int unsigned tb,
                                                 input int unsigned lb);
      logic [63:0] one;
      logic [63:0] quarter;
      logic [63:0] lmax;
      logic [63:0] quad;
      logic [63:0] r;
      logic [63:0] q;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] u;
      one     = 64'd1 << 30;
      quarter = 64'd1 << (tb - 2);
      lmax    = (64'd1 << lb) - 64'd1;
      quad    = (idx >> (tb - 2)) & 64'd3;
      r       = idx & (quarter - 64'd1);
      q       = quad[0] ? (quarter - r) : r;
      x       = (q * 64'd1686629713) >> (tb - 2);
      x2      = (x * x) >> 30;
      t       = one - x2 / 64'd72;
      t       = one - ((x2 * t) >> 30) / 64'd42;
      t       = one - ((x2 * t) >> 30) / 64'd20;
      t       = one - ((x2 * t) >> 30) / 64'd6;
      s       = (x * t) >> 30;
      if (s > one) begin
         s = one;
      end
      u = quad[1] ? (one - s) : (one + s);
      return ((u * lmax + one) >> 31) & lmax;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/usl_req_if.sv =====
// Request channel: valid/ready plus the per-frame oscillator rate.
// Depends on usl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface usl_req_if;
   logic                       valid;
   logic                       ready;
   logic [usl_pkg::RATE_W-1:0] rate_hz;

   modport source (output valid, output rate_hz, input ready);
   modport sink   (input valid, input rate_hz, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/usl_rsp_if.sv =====
// Response channel: valid/ready plus the unipolar level.
// Depends on usl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface usl_rsp_if #(
   parameter int LEVEL_BITS = usl_pkg::LEVEL_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/usl_step.sv =====
// Phase step stage: rate times scale, rescaled to phase units, registered.
// Depends on usl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usl_step #(
   parameter int PHASE_BITS = usl_pkg::PHASE_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire logic [usl_pkg::RATE_W-1:0]  rate,
   input  wire logic [usl_pkg::SCALE_W-1:0] scale,
   output logic [PHASE_BITS-5:0]            step
);
   import usl_pkg::*;

   // step = (prod << UP) >> (16 + DN), PHASE_BITS - 4 bits wide
   localparam int UP     = (PHASE_BITS > 32) ? (PHASE_BITS - 32) : 0;
   localparam int DN     = (PHASE_BITS < 32) ? (32 - PHASE_BITS) : 0;
   localparam int WIDE_W = PROD_W + UP;
   localparam int STEP_W = PHASE_BITS - 4;

   logic [PROD_W-1:0] prod;
   logic [WIDE_W-1:0] prod_ext;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] step_ff;

   assign prod     = PROD_W'(rate) * PROD_W'(scale);
   assign prod_ext = WIDE_W'(prod) << UP;
   assign step_in  = STEP_W'(prod_ext >> (16 + DN));

   always_ff @(posedge clock) begin
      if (load) begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/usl_phase.sv =====
// Phase accumulator: adds the step, forces zero on reaching one turn.
// Depends on usl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usl_phase #(
   parameter int PHASE_BITS = usl_pkg::PHASE_BITS_DEF,
   parameter int TABLE_BITS = usl_pkg::TABLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [PHASE_BITS-5:0] step,
   output logic [TABLE_BITS-1:0]      index
);
   import usl_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS:0]   sum;

   assign sum      = {1'b0, phase_ff} + (PHASE_BITS + 1)'(step);
   // carry out means one turn reached: restart at zero, no wrap
   assign phase_in = sum[PHASE_BITS] ? '0 : sum[PHASE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   assign index = phase_ff[PHASE_BITS-1 -: TABLE_BITS];
endmodule
`default_nettype wire

// ===== hw/rtl/usl_rom.sv =====
// Sine ROM, full wave, built at elaboration, registered read.
// Depends on usl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usl_rom #(
   parameter int TABLE_BITS = usl_pkg::TABLE_BITS_DEF,
   parameter int LEVEL_BITS = usl_pkg::LEVEL_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [TABLE_BITS-1:0] addr,
   output logic [LEVEL_BITS-1:0]      data
);
   import usl_pkg::*;

   localparam int DEPTH = 2 ** TABLE_BITS;

   logic [LEVEL_BITS-1:0] rom_tbl [DEPTH];
   logic [LEVEL_BITS-1:0] data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      assign rom_tbl[i] = LEVEL_BITS'(usl_rom_level(64'(i), TABLE_BITS, LEVEL_BITS));
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= rom_tbl[addr];
      end
   end

   assign data = data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/unipolar_sine_lfo.sv =====
// Unipolar sine LFO. A response becomes valid once its frame has passed every stage register below.
// Throughput: one frame per cycle; the pipeline only stalls while a response waits.
// Stages: input register -> step multiply register -> phase add / ROM read register.
// Reset (synchronous, active high): pipeline empty, phase 0, enabled 0, scale 89478.
// While disabled, frames are taken and dropped, and the phase holds.
`timescale 1ns / 1ps
`default_nettype none
module unipolar_sine_lfo #(
   parameter int PHASE_BITS = usl_pkg::PHASE_BITS_DEF,
   parameter int TABLE_BITS = usl_pkg::TABLE_BITS_DEF,
   parameter int LEVEL_BITS = usl_pkg::LEVEL_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   usl_req_if.sink                             req_if,
   usl_rsp_if.source                           rsp_if,
   input  wire logic                           csr_we,
   input  wire logic [usl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [usl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import usl_pkg::*;
   `include "unipolar_sine_lfo_macros.svh"

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   logic               enabled_ff;
   logic [SCALE_W-1:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         scale_ff   <= SCALE_RESET;
      end else if (csr_we) begin
         unique case (usl_csr_idx_type'(csr_index))
            CSR_ENABLED:     enabled_ff <= csr_wdata[0];
            CSR_PHASE_SCALE: scale_ff   <= csr_wdata[SCALE_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: every stage moves together unless the
   // response register is full and not being drained.
   // ---------------------------------------------------------------
   logic advance;
   logic in_vld_ff;     // stage 1: captured rate
   logic step_vld_ff;   // stage 2: step ready, phase add pending
   logic out_vld_ff;    // stage 3: level in response register

   assign advance      = !out_vld_ff || rsp_if.ready;
   assign req_if.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         step_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (advance) begin
         // frames arriving while disabled are consumed with no response
         in_vld_ff   <= req_if.valid && enabled_ff;
         step_vld_ff <= in_vld_ff;
         out_vld_ff  <= step_vld_ff;
      end
   end

   // Stage 1: input register
   logic [RATE_W-1:0] rate_ff;

   always_ff @(posedge clock) begin
      if (advance && req_if.valid) begin
         rate_ff <= req_if.rate_hz;
      end
   end

   // Stage 2: step = rate * scale, rescaled
   logic [PHASE_BITS-5:0] step;

   usl_step #(
      .PHASE_BITS (PHASE_BITS)
   ) u_step (
      .clock (clock),
      .load  (advance),
      .rate  (rate_ff),
      .scale (scale_ff),
      .step  (step)
   );

   // Stage 3: ROM read at the current phase, phase advances in the same edge
   logic                  fire;
   logic [TABLE_BITS-1:0] phase_idx;
   logic [LEVEL_BITS-1:0] level;

   assign fire = advance && step_vld_ff;

   usl_phase #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (TABLE_BITS)
   ) u_phase (
      .clock   (clock),
      .reset   (reset),
      .advance (fire),
      .step    (step),
      .index   (phase_idx)
   );

   usl_rom #(
      .TABLE_BITS (TABLE_BITS),
      .LEVEL_BITS (LEVEL_BITS)
   ) u_rom (
      .clock (clock),
      .rd_en (fire),
      .addr  (phase_idx),
      .data  (level)
   );

   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.level = level;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `USL_ASSERT(a_phase_hold, !fire |=> $stable(phase_idx), "phase moved without a frame")
   `USL_ASSERT(a_drop_disabled, (advance && !enabled_ff) |=> !in_vld_ff, "frame kept while off")
   `USL_ASSERT(a_out_source, $rose(out_vld_ff) |-> $past(step_vld_ff), "response from nowhere")

endmodule
`default_nettype wire

// ===== tb/sv/usl_level_checker.sv =====
`timescale 1ns / 1ps
// Level checker for the unipolar sine LFO: follows the phase, predicts each level and
// compares it with the response channel. Depends on usl_pkg, usl_req_if and usl_rsp_if.
module usl_level_checker (
   input  logic                           clock,
   input  logic                           reset,
   usl_req_if                             req,
   usl_rsp_if                             rsp,
   input  logic                           csr_we,
   input  logic [usl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [usl_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);

   localparam int PHASE_W = usl_pkg::PHASE_BITS_DEF;
   localparam int TABLE_W = usl_pkg::TABLE_BITS_DEF;
   localparam int LEVEL_W = usl_pkg::LEVEL_BITS_DEF;
   localparam int PROD_W  = usl_pkg::PROD_W;

   localparam logic [63:0] Q30_UNIT  = 64'd1 << 30;
   localparam logic [63:0] QTR_WAVE  = 64'd1 << (TABLE_W - 2);
   localparam logic [63:0] LEVEL_TOP = (64'd1 << LEVEL_W) - 64'd1;
   localparam logic [63:0] HALF_PI   = 64'd1686629713;

   logic [LEVEL_W-1:0]          sine_levels [1 << TABLE_W];
   logic [LEVEL_W-1:0]          expected_levels [$];
   logic [PHASE_W-1:0]          phase;
   logic                        osc_enabled;
   logic [usl_pkg::SCALE_W-1:0] phase_step_scale;
   int                          errors;

   // sin(x) for x in [0, pi/2], Q30, Horner form of the Taylor series to x^9
   function automatic logic [63:0] q30_sine(input logic [63:0] x);
      logic [63:0] xx;
      logic [63:0] h;
      logic [63:0] s;
      xx = (x * x) >> 30;
      h  = Q30_UNIT - xx / 64'd72;
      h  = Q30_UNIT - ((xx * h) >> 30) / 64'd42;
      h  = Q30_UNIT - ((xx * h) >> 30) / 64'd20;
      h  = Q30_UNIT - ((xx * h) >> 30) / 64'd6;
      s  = (x * h) >> 30;
      return (s > Q30_UNIT) ? Q30_UNIT : s;
   endfunction

   // (sin + 1) / 2 at table entry idx, folded onto the first quarter wave
   function automatic logic [LEVEL_W-1:0] table_level(input int unsigned idx);
      logic [63:0] quadrant;
      logic [63:0] offset;
      logic [63:0] folded;
      logic [63:0] angle;
      logic [63:0] s;
      logic [63:0] u;
      quadrant = (64'(idx) >> (TABLE_W - 2)) & 64'd3;
      offset   = 64'(idx) & (QTR_WAVE - 64'd1);
      folded   = quadrant[0] ? (QTR_WAVE - offset) : offset;
      angle    = (folded * HALF_PI) >> (TABLE_W - 2);
      s        = q30_sine(angle);
      u        = quadrant[1] ? (Q30_UNIT - s) : (Q30_UNIT + s);
      return LEVEL_W'((u * LEVEL_TOP + Q30_UNIT) >> 31);
   endfunction

   initial begin
      for (int i = 0; i < (1 << TABLE_W); i++) begin
         sine_levels[i] = table_level(i);
      end
   end

   always @(posedge clock) begin : predict_and_compare
      logic [LEVEL_W-1:0] want;
      logic [PROD_W-1:0]  product;
      logic [PHASE_W:0]   sum;
      if (reset) begin
         phase            = '0;
         osc_enabled      = 1'b0;
         phase_step_scale = usl_pkg::SCALE_RESET;
         expected_levels.delete();
      end else begin
         // response first: a level predicted at this edge cannot leave at the same edge
         if (rsp.valid && rsp.ready) begin
            if (expected_levels.size() == 0) begin
               errors++;
               $display("%0t: unexpected level transfer, expected none, got %0d",
                        $time, rsp.level);
            end else begin
               want = expected_levels.pop_front();
               if (rsp.level !== want) begin
                  errors++;
                  $display("%0t: level mismatch, expected %0d, got %0d",
                           $time, want, rsp.level);
               end
            end
         end
         if (req.valid && req.ready && osc_enabled) begin
            expected_levels.push_back(sine_levels[phase[PHASE_W-1 -: TABLE_W]]);
            product = PROD_W'(req.rate_hz) * PROD_W'(phase_step_scale);
            sum     = {1'b0, phase} + (PHASE_W + 1)'(product >> 16);
            // reaching or passing one turn restarts at zero
            phase   = sum[PHASE_W] ? '0 : sum[PHASE_W-1:0];
         end
         if (csr_we) begin
            case (usl_pkg::usl_csr_idx_type'(csr_index))
               usl_pkg::CSR_ENABLED:     osc_enabled = csr_wdata[0];
               usl_pkg::CSR_PHASE_SCALE: phase_step_scale = csr_wdata[usl_pkg::SCALE_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= errors;
      pending    <= expected_levels.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the unipolar sine LFO bench: clock, reset, frame and register stimulus, and
// the verdict. Depends on usl_pkg, the channel interfaces and usl_level_checker.
module testbench;

   localparam int CLK_PERIOD    = 12;
   localparam int LATENCY       = 2;     // drain margin for settle and the final wait
   localparam int LONG_HOLD     = 300;   // cycles the receiver sits out once
   localparam int STALL_LIMIT   = 2000;  // cycles without any transfer
   localparam int RANDOM_FRAMES = 600;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [usl_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [usl_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                             fail_count;
   int                             pending;
   int                             idle_cycles;
   bit                             hold_wanted;
   bit                             hold_done;

   usl_req_if req_if ();
   usl_rsp_if rsp_if ();

   unipolar_sine_lfo u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   usl_level_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Idle length: half none, most of the rest short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Rate: mostly anything in 24 bits, with the ends and slow rates mixed in.
   function automatic logic [usl_pkg::RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2:       return usl_pkg::RATE_W'($urandom_range(1, 255));
         default: return usl_pkg::RATE_W'($urandom);
      endcase
   endfunction

   // Scale: the legal ends, the reset value, zero, all ones, and random values.
   function automatic logic [usl_pkg::SCALE_W-1:0] pick_scale();
      case ($urandom_range(0, 7))
         0:       return usl_pkg::SCALE_W'(22369);
         1:       return usl_pkg::SCALE_W'(536871);
         2:       return '1;
         3:       return '0;
         4:       return usl_pkg::SCALE_RESET;
         5, 6:    return usl_pkg::SCALE_W'($urandom_range(22369, 536871));
         default: return usl_pkg::SCALE_W'($urandom);
      endcase
   endfunction

   // One frame transfer. valid stays up after the transfer, so back-to-back frames
   // never drop and re-raise valid within one step.
   task automatic send_frame(input logic [usl_pkg::RATE_W-1:0] rate, input int gap);
      if (gap > 0) begin
         req_if.valid   <= 1'b0;
         req_if.rate_hz <= usl_pkg::RATE_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rate_hz <= rate;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stop offering, wait for every predicted level, then let frames that give no
   // level (disabled) run out of the pipe.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Both registers, scale first, on back-to-back cycles; only while idle.
   task automatic program_regs(input logic [usl_pkg::CSR_DATA_W-1:0] enable_word,
                               input logic [usl_pkg::SCALE_W-1:0]    scale);
      csr_we    <= 1'b1;
      csr_index <= usl_pkg::CSR_PHASE_SCALE;
      csr_wdata <= usl_pkg::CSR_DATA_W'(scale);
      @(posedge clock);
      csr_index <= usl_pkg::CSR_ENABLED;
      csr_wdata <= enable_word;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Receiver pacing: random stalls, calm stretches, and once a long hold-off that
   // lets the pipe fill and back up into the request side.
   initial begin : rsp_pacing
      int stall;
      int calm_left;
      int held;
      calm_left     = 0;
      hold_done     = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_if.ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD) begin
               @(posedge clock);
               held++;
            end
            hold_done = 1'b1;
         end else begin
            if (calm_left > 0) begin
               stall = 0;
               calm_left--;
            end else begin
               if ($urandom_range(0, 24) == 0) calm_left = $urandom_range(30, 80);
               stall = pick_gap();
            end
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Watchdog: any transfer on either channel or a register write counts as progress.
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("unipolar_sine_lfo test failed");
      $finish;
   end

   initial begin : stimulus
      logic [usl_pkg::CSR_DATA_W-1:0] enable_word;
      int                             frames_sent;
      int                             phase_len;
      bit                             phase_on;
      bit                             sender_calm;
      bit                             first_phase;
      hold_wanted     = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rate_hz <= '0;
      csr_we         <= 1'b0;
      csr_index      <= usl_pkg::CSR_ENABLED;
      csr_wdata      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // Off after reset: frames are taken and dropped, phase stays at zero.
      send_frame('1, 0);
      send_frame('0, 0);
      send_frame(usl_pkg::RATE_W'($urandom), 1);
      settle();

      // All scale bits set. Rate 0 leaves the phase at zero; seventeen max-rate frames
      // carry it past one turn, so the phase restarts at zero after the last frame.
      program_regs(usl_pkg::CSR_DATA_W'(1), '1);
      send_frame('0, 0);
      repeat (17) send_frame('1, 0);
      settle();

      // Upper enable bits set but bit 0 clear: still off. Zero scale written.
      program_regs(usl_pkg::CSR_DATA_W'('1) ^ usl_pkg::CSR_DATA_W'(1), '0);
      send_frame('1, 0);
      send_frame('1, 2);
      settle();

      // On with zero scale: the phase must not move.
      program_regs(usl_pkg::CSR_DATA_W'(1), '0);
      send_frame('1, 0);
      send_frame('1, 0);
      settle();

      // Both ends of the legal scale range at the top rate.
      program_regs(usl_pkg::CSR_DATA_W'(1), usl_pkg::SCALE_W'(22369));
      send_frame('1, 0);
      send_frame('1, 0);
      settle();
      program_regs(usl_pkg::CSR_DATA_W'(1), usl_pkg::SCALE_W'(536871));
      send_frame('1, 0);
      send_frame('1, 1);
      settle();

      // --- random ---
      // Each run of frames gets fresh settings; a few runs are disabled. The first run
      // is enabled, sent without gaps, and coincides with the long receiver hold-off.
      frames_sent = 0;
      first_phase = 1'b1;
      while (frames_sent < RANDOM_FRAMES) begin
         phase_on    = first_phase || ($urandom_range(0, 6) != 0);
         sender_calm = first_phase || ($urandom_range(0, 3) == 0);
         phase_len   = first_phase ? 90 : $urandom_range(20, 80);
         enable_word = usl_pkg::CSR_DATA_W'($urandom);
         enable_word[0] = phase_on;
         settle();
         program_regs(enable_word, pick_scale());
         if (first_phase) hold_wanted = 1'b1;
         for (int i = 0; i < phase_len; i++) begin
            send_frame(pick_rate(), sender_calm ? 0 : pick_gap());
            if (phase_on) frames_sent++;
            // now and then the sender waits for the pipe to empty mid-run
            if (!sender_calm && $urandom_range(0, 149) == 0) settle();
         end
         first_phase = 1'b0;
      end

      settle();
      repeat (2 * LATENCY + 2) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("unipolar_sine_lfo test passed");
      end else begin
         $display("unipolar_sine_lfo test failed");
      end
      $finish;
   end

endmodule

// ===== unipolar_sine_lfo.f =====
+incdir+hw/rtl
hw/rtl/usl_pkg.sv
hw/rtl/usl_req_if.sv
hw/rtl/usl_rsp_if.sv
hw/rtl/usl_step.sv
hw/rtl/usl_phase.sv
hw/rtl/usl_rom.sv
hw/rtl/unipolar_sine_lfo.sv
tb/sv/usl_level_checker.sv
tb/sv/testbench.sv
